>>> design/interval_set_merge_unit_defines.svh
// ----------------------------------------------------------------------------
// Interval set merge unit: assertion macros
// Shared checking macros for the interval set merge unit.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_MERGE_UNIT_DEFINES_SVH
`define INTERVAL_SET_MERGE_UNIT_DEFINES_SVH

// The condition must never hold while out of reset.
`define ISM_CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ISM_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISM_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ism_pkg.sv
// ----------------------------------------------------------------------------
// Interval set merge package
// Types and constants shared by the merge unit and its range cells.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int OFS_W     = 48;
  localparam int CNT_OUT_W = 5;

  typedef logic [OFS_W-1:0] ofs_t;

  typedef struct packed {
    ofs_t range_begin;
    ofs_t range_end;
  } in_item_t;

  typedef struct packed {
    logic                 rejected;
    logic                 merged;
    logic                 overflow;
    logic [CNT_OUT_W-1:0] range_count;
    ofs_t                 first_begin;
    ofs_t                 first_end;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_ABS
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_FLAG,
    OP_MERGE,
    OP_ABSORB,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    ofs_t     range_begin;
    ofs_t     range_end;
  } cell_ctl_t;

  // What one cell shows to its neighbours.
  typedef struct packed {
    ofs_t start;
    ofs_t stop;
    logic hit;
    logic lt;
    logic ge;
  } link_t;

  typedef struct packed {
    ofs_t start;
    ofs_t stop;
  } range_t;

  // A range ending at a_end overlaps or abuts one starting at b_begin.
  // The end + 1 is taken one bit wider so that it cannot wrap.
  function automatic logic touches(ofs_t a_end, ofs_t b_begin);
    logic [OFS_W:0] a_inc;
    a_inc = {1'b0, a_end} + {{OFS_W{1'b0}}, 1'b1};
    return (b_begin == '0) || (a_inc >= {1'b0, b_begin});
  endfunction

endpackage

>>> design/ism_cell.sv
// ----------------------------------------------------------------------------
// Interval set merge range cell
// Holds one stored range and its compare flags, and trades ranges with its
// neighbours when a range is inserted or when merged ranges are squeezed out.
// ----------------------------------------------------------------------------
module ism_cell (
  input  logic              clk,
  input  ism_pkg::cell_ctl_t ctl_i,
  input  logic              vld_i,
  input  ism_pkg::link_t    left_i,
  input  ism_pkg::link_t    right_i,
  output ism_pkg::link_t    link_o,
  output ism_pkg::range_t   nxt_o
);

  ism_pkg::ofs_t start_r, start_nxt;
  ism_pkg::ofs_t stop_r, stop_nxt;
  logic          hit_r, hit_nxt;
  logic          lt_r, lt_nxt;
  logic          ge_r, ge_nxt;
  logic          first;

  // This cell is the lowest one that the new range touches.
  assign first = hit_r && !left_i.hit;

  always_comb begin
    start_nxt = start_r;
    stop_nxt  = stop_r;
    hit_nxt   = hit_r;
    lt_nxt    = lt_r;
    ge_nxt    = ge_r;
    case (ctl_i.op)
      ism_pkg::OP_FLAG: begin
        hit_nxt = vld_i && ism_pkg::touches(ctl_i.range_end, start_r)
                  && ism_pkg::touches(stop_r, ctl_i.range_begin);
        lt_nxt  = vld_i && (ctl_i.range_begin < start_r);
        ge_nxt  = !vld_i || ism_pkg::touches(stop_r, ctl_i.range_begin);
      end
      ism_pkg::OP_MERGE: begin
        if (first) begin
          start_nxt = (start_r < ctl_i.range_begin) ? start_r : ctl_i.range_begin;
          stop_nxt  = (stop_r > ctl_i.range_end) ? stop_r : ctl_i.range_end;
        end
      end
      ism_pkg::OP_ABSORB: begin
        if (first) begin
          stop_nxt = (stop_r > right_i.stop) ? stop_r : right_i.stop;
        end else if (left_i.ge) begin
          start_nxt = right_i.start;
          stop_nxt  = right_i.stop;
          hit_nxt   = right_i.hit;
        end
      end
      ism_pkg::OP_INSERT: begin
        if (lt_r || !vld_i) begin
          if (left_i.lt) begin
            start_nxt = left_i.start;
            stop_nxt  = left_i.stop;
          end else begin
            start_nxt = ctl_i.range_begin;
            stop_nxt  = ctl_i.range_end;
          end
        end
      end
      default: begin
        start_nxt = start_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    stop_r  <= stop_nxt;
    hit_r   <= hit_nxt;
    lt_r    <= lt_nxt;
    ge_r    <= ge_nxt;
  end

  assign link_o.start = start_r;
  assign link_o.stop  = stop_r;
  assign link_o.hit   = hit_r;
  assign link_o.lt    = lt_r;
  assign link_o.ge    = ge_r;

  assign nxt_o.start = start_nxt;
  assign nxt_o.stop  = stop_nxt;

endmodule

>>> design/interval_set_merge_unit.sv
// ----------------------------------------------------------------------------
// Interval set merge unit
// Keeps a sorted table of disjoint inclusive byte ranges in a row of cells.
// ----------------------------------------------------------------------------
// Usage. Each input transaction on in_data carries a range begin and end.
// A transaction is taken when in_valid is high and in_stall is low; in_stall
// is high while an earlier transaction is still being worked on. Every input
// transaction produces exactly one output transaction on out_data, held in an
// output register until out_valid is high with out_stall low.
// Timing. The cells compare the new range against every stored range at the
// edge that accepts it. Then, in the update state, the table is updated: the
// range is inserted, merged into the lowest stored range it touches, or
// dropped. Each further stored range swallowed by a merge is taken in an
// absorb step of its own; the cells shift one place left per cycle unless the
// output holds them. No new transaction is taken until this one is finished.
// If the output register is still full when a result is ready, the unit waits
// with the table untouched until the receiver takes the pending transaction.
// Reset empties the table (the count drops to zero) and clears out_valid.
// ----------------------------------------------------------------------------
`include "interval_set_merge_unit_defines.svh"

module interval_set_merge_unit #(
  parameter int MAX_RANGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ism_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ism_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  ism_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  ism_pkg::ofs_t       beg_r, end_r;
  logic                rej_r;
  logic                out_valid_r, out_valid_nxt;
  ism_pkg::out_item_t  out_data_r, out_data_nxt;

  ism_pkg::cell_ctl_t  ctl;
  ism_pkg::link_t      link_w  [MAX_RANGES];
  ism_pkg::link_t      left_w  [MAX_RANGES];
  ism_pkg::link_t      right_w [MAX_RANGES];
  ism_pkg::range_t     nxt_w   [MAX_RANGES];
  logic [MAX_RANGES-1:0] vld_v;
  logic [MAX_RANGES-1:0] hit_v;

  logic                accept;
  logic                any_hit;
  logic                more_pair;
  logic                more_triple;
  logic                full;
  logic                final_step;
  logic                out_free;
  logic                go;
  logic                load_out;
  logic [CNT_W+ism_pkg::CNT_OUT_W-1:0] count_ext;

  // The row of cells. Cells at the ends see an empty neighbour.
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

    assign vld_v[i] = IDX < count_r;
    assign hit_v[i] = link_w[i].hit;

    if (i == 0) begin : g_left_edge
      assign left_w[i] = '0;
    end else begin : g_left_link
      assign left_w[i] = link_w[i-1];
    end

    if (i == MAX_RANGES - 1) begin : g_right_edge
      assign right_w[i] = '0;
    end else begin : g_right_link
      assign right_w[i] = link_w[i+1];
    end

    ism_cell u_cell (
      .clk    (clk),
      .ctl_i  (ctl),
      .vld_i  (vld_v[i]),
      .left_i (left_w[i]),
      .right_i(right_w[i]),
      .link_o (link_w[i]),
      .nxt_o  (nxt_w[i])
    );
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ism_pkg::ST_IDLE);
  assign full     = (count_r == CNT_W'(MAX_RANGES));

  // Touched cells always sit next to each other, so adjacent pairs tell us
  // whether more than one stored range is involved.
  assign any_hit     = |hit_v;
  assign more_pair   = |(hit_v & (hit_v >> 1));
  assign more_triple = |(hit_v & (hit_v >> 1) & (hit_v >> 2));

  assign out_free = !out_valid_r || !out_stall;

  // The update step is the last one unless further ranges remain to be
  // absorbed; an absorb step is last when only one neighbour is left.
  always_comb begin
    case (state_r)
      ism_pkg::ST_UPD: final_step = rej_r || !any_hit || !more_pair;
      ism_pkg::ST_ABS: final_step = !more_triple;
      default:         final_step = 1'b0;
    endcase
  end

  assign go       = !final_step || out_free;
  assign load_out = final_step && go;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ism_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ism_pkg::ST_UPD;
        end
      end
      ism_pkg::ST_UPD: begin
        if (go) begin
          state_nxt = final_step ? ism_pkg::ST_IDLE : ism_pkg::ST_ABS;
        end
      end
      ism_pkg::ST_ABS: begin
        if (load_out) begin
          state_nxt = ism_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ism_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the cells and the count update.
  always_comb begin
    ctl.op          = ism_pkg::OP_HOLD;
    ctl.range_begin = beg_r;
    ctl.range_end   = end_r;
    count_nxt       = count_r;
    case (state_r)
      ism_pkg::ST_IDLE: begin
        ctl.range_begin = in_data.range_begin;
        ctl.range_end   = in_data.range_end;
        if (accept) begin
          ctl.op = ism_pkg::OP_FLAG;
        end
      end
      ism_pkg::ST_UPD: begin
        if (go && !rej_r) begin
          if (any_hit) begin
            ctl.op = ism_pkg::OP_MERGE;
          end else if (!full) begin
            ctl.op    = ism_pkg::OP_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ism_pkg::ST_ABS: begin
        if (go) begin
          ctl.op    = ism_pkg::OP_ABSORB;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        ctl.op = ism_pkg::OP_HOLD;
      end
    endcase
  end

  // The result describes the table as it stands after the final step, so it
  // is built from the next count and the next contents of the lowest cell.
  assign count_ext = {{ism_pkg::CNT_OUT_W{1'b0}}, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.rejected    = rej_r;
      out_data_nxt.merged      = !rej_r && any_hit;
      out_data_nxt.overflow    = !rej_r && !any_hit && full;
      out_data_nxt.range_count = count_ext[ism_pkg::CNT_OUT_W-1:0];
      out_data_nxt.first_begin = (count_nxt != '0) ? nxt_w[0].start : '0;
      out_data_nxt.first_end   = (count_nxt != '0) ? nxt_w[0].stop : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ism_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      beg_r <= in_data.range_begin;
      end_r <= in_data.range_end;
      rej_r <= (in_data.range_begin >= in_data.range_end);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ISM_CHK_NEVER(a_count_in_range, count_r > CNT_W'(MAX_RANGES),
                 "range count above table size")
  `ISM_CHK_NEXT(a_accept_to_update, accept, state_r == ism_pkg::ST_UPD,
                "accept not followed by update")
  `ISM_CHK_SAME(a_absorb_is_merge, state_r == ism_pkg::ST_ABS,
                any_hit && !rej_r && more_pair, "absorb without a multi-range merge")
  `ISM_CHK_NEXT(a_result_ends_work, load_out, state_r == ism_pkg::ST_IDLE && out_valid_r,
                "result loaded but unit not idle")

endmodule

>>> tb/interval_set_merge_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval set merge unit testbench
// Sends byte ranges into the merge unit and checks every output transaction
// against a behavioural copy of the range table kept here. A short directed
// list covers rejection, the top and bottom offsets, merges that swallow
// several stored ranges and a full table; random ranges follow, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module interval_set_merge_unit_tb;

  localparam int            SLOTS        = 16;
  localparam int            RANDOM_ITEMS = 550;
  localparam int            CYCLE_LIMIT  = 200000;
  localparam int            DRAIN_CYCLES = 24;
  localparam ism_pkg::ofs_t TOP_OFS      = '1;

  // One row of the directed list. Where want_known is set, want is the
  // expected transaction typed in by hand; otherwise the table copy decides.
  typedef struct {
    ism_pkg::ofs_t      lo;
    ism_pkg::ofs_t      hi;
    bit                 want_known;
    ism_pkg::out_item_t want;
  } plan_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ism_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ism_pkg::out_item_t out_data;

  // Our own copy of the range table: sorted, disjoint and not touching.
  ism_pkg::ofs_t      span_lo [SLOTS];
  ism_pkg::ofs_t      span_hi [SLOTS];
  int                 span_cnt = 0;

  ism_pkg::out_item_t pending_results [$];
  plan_entry_t        plan [$];

  bit          no_idle = 1'b0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          sent_cnt = 0;
  int          rej_cnt = 0;
  int          merge_cnt = 0;
  int          ovf_cnt = 0;
  int          checked_cnt = 0;
  int          peak_cnt = 0;

  interval_set_merge_unit #(
    .MAX_RANGES(SLOTS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Safety net: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("interval_set_merge_unit_tb NOT OK");
      $finish;
    end
  end

  // A range ending at a_end overlaps or abuts one starting at b_begin. The
  // end + 1 test is turned round into begin - 1 so that nothing can wrap; a
  // stored begin of zero is caught first and counts as touching any range end.
  function automatic bit abuts(ism_pkg::ofs_t a_end, ism_pkg::ofs_t b_begin);
    return (b_begin == '0) || (a_end >= b_begin - 1'b1);
  endfunction

  // Applies one range to the table copy and returns the transaction the unit
  // should answer with.
  function automatic ism_pkg::out_item_t merge_range(ism_pkg::ofs_t b, ism_pkg::ofs_t e);
    ism_pkg::out_item_t res;
    int        n;
    int        lo;
    int        hi;
    int        gone;
    int        p;
    res = '0;
    n   = span_cnt;
    if (b >= e) begin
      res.rejected = 1'b1;
    end else begin
      lo = n;
      hi = 0;
      for (int i = 0; i < n; i++) begin
        if (abuts(e, span_lo[i]) && abuts(span_hi[i], b)) begin
          if (lo == n) lo = i;
          hi = i;
        end
      end
      if (lo < n) begin
        // Everything from lo to hi collapses into the entry at lo.
        gone        = hi - lo;
        span_lo[lo] = (span_lo[lo] < b) ? span_lo[lo] : b;
        span_hi[lo] = (span_hi[hi] > e) ? span_hi[hi] : e;
        for (int i = hi + 1; i < n; i++) begin
          span_lo[i - gone] = span_lo[i];
          span_hi[i - gone] = span_hi[i];
        end
        n -= gone;
        res.merged = 1'b1;
      end else if (n >= SLOTS) begin
        res.overflow = 1'b1;
      end else begin
        p = n;
        for (int i = 0; i < n; i++) begin
          if (b < span_lo[i]) begin
            p = i;
            break;
          end
        end
        for (int i = n; i > p; i--) begin
          span_lo[i] = span_lo[i - 1];
          span_hi[i] = span_hi[i - 1];
        end
        span_lo[p] = b;
        span_hi[p] = e;
        n++;
      end
      span_cnt = n;
    end
    res.range_count = n[ism_pkg::CNT_OUT_W-1:0];
    if (n != 0) begin
      res.first_begin = span_lo[0];
      res.first_end   = span_hi[0];
    end
    return res;
  endfunction

  function automatic ism_pkg::ofs_t rand_ofs();
    return ism_pkg::ofs_t'({$urandom, $urandom});
  endfunction

  function automatic plan_entry_t plan_row(ism_pkg::ofs_t lo, ism_pkg::ofs_t hi,
                                           bit want_known = 1'b0,
                                           ism_pkg::out_item_t want = '0);
    plan_entry_t r;
    r.lo         = lo;
    r.hi         = hi;
    r.want_known = want_known;
    r.want       = want;
    return r;
  endfunction

  function automatic ism_pkg::out_item_t hand_result(bit rej, bit mrg, bit ovf, int cnt,
                                                     ism_pkg::ofs_t fb, ism_pkg::ofs_t fe);
    ism_pkg::out_item_t r;
    r.rejected    = rej;
    r.merged      = mrg;
    r.overflow    = ovf;
    r.range_count = cnt[ism_pkg::CNT_OUT_W-1:0];
    r.first_begin = fb;
    r.first_end   = fe;
    return r;
  endfunction

  // Presents one range transaction, with a random gap in front of it, and
  // holds it steady until the unit takes it. The expectation is recorded at
  // the accepting edge, so the table copy advances in acceptance order.
  task automatic send_range(ism_pkg::ofs_t b, ism_pkg::ofs_t e, bit want_known,
                            ism_pkg::out_item_t want);
    ism_pkg::in_item_t  item;
    ism_pkg::out_item_t model;
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.range_begin = b;
    item.range_end   = e;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    model = merge_range(b, e);
    pending_results.push_back(want_known ? want : model);
    sent_cnt++;
    if (model.rejected) rej_cnt++;
    if (model.merged) merge_cnt++;
    if (model.overflow) ovf_cnt++;
    if (span_cnt > peak_cnt) peak_cnt = span_cnt;
  endtask

  // Output side: every taken transaction is held against the oldest
  // expectation, field by field. The stall for the next edge is chosen here
  // as well, so that it changes only at the clock.
  always @(posedge clk) begin
    ism_pkg::out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("output transaction with nothing expected: %p", out_data);
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        checked_cnt++;
        if (out_data.rejected !== exp_res.rejected) begin
          $error("rejected: expected %0d actual %0d", exp_res.rejected, out_data.rejected);
          fail_cnt++;
        end
        if (out_data.merged !== exp_res.merged) begin
          $error("merged: expected %0d actual %0d", exp_res.merged, out_data.merged);
          fail_cnt++;
        end
        if (out_data.overflow !== exp_res.overflow) begin
          $error("overflow: expected %0d actual %0d", exp_res.overflow, out_data.overflow);
          fail_cnt++;
        end
        if (out_data.range_count !== exp_res.range_count) begin
          $error("range_count: expected %0d actual %0d", exp_res.range_count,
                 out_data.range_count);
          fail_cnt++;
        end
        if (out_data.first_begin !== exp_res.first_begin) begin
          $error("first_begin: expected %0h actual %0h", exp_res.first_begin,
                 out_data.first_begin);
          fail_cnt++;
        end
        if (out_data.first_end !== exp_res.first_end) begin
          $error("first_end: expected %0h actual %0h", exp_res.first_end,
                 out_data.first_end);
          fail_cnt++;
        end
      end
    end
    out_stall <= !no_idle && ($urandom_range(0, 99) < 35);
  end

  initial begin
    ism_pkg::ofs_t b;
    ism_pkg::ofs_t e;
    ism_pkg::ofs_t base;
    int   mode;
    int   k;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed list. The first rows are checked against hand-typed results:
    // rejection on an empty table, at both extremes, and the first insert.
    plan.push_back(plan_row('0, '0, 1'b1, hand_result(1'b1, 1'b0, 1'b0, 0, '0, '0)));
    plan.push_back(plan_row(TOP_OFS, '0, 1'b1, hand_result(1'b1, 1'b0, 1'b0, 0, '0, '0)));
    plan.push_back(plan_row(TOP_OFS, TOP_OFS, 1'b1,
                            hand_result(1'b1, 1'b0, 1'b0, 0, '0, '0)));
    plan.push_back(plan_row(48'd1000, 48'd2000, 1'b1,
                            hand_result(1'b0, 1'b0, 1'b0, 1, 48'd1000, 48'd2000)));
    // A range right at the top offset, then one starting at zero.
    plan.push_back(plan_row(TOP_OFS - 1, TOP_OFS));
    plan.push_back(plan_row('0, 48'd5));
    // A stored begin of zero touches anything, but the other side of the
    // test keeps this one separate.
    plan.push_back(plan_row(48'd7, 48'd9));
    // Bridges the gap, swallowing both low ranges.
    plan.push_back(plan_row(48'd6, 48'd7));
    // Touches the top range from below without overlapping it.
    plan.push_back(plan_row(TOP_OFS - 3, TOP_OFS - 2));
    // Fill the table up to its last slot.
    for (int i = 0; i < 13; i++) begin
      plan.push_back(plan_row(48'd3000 + 100 * i, 48'd3010 + 100 * i));
    end
    // Full table: a separate range is dropped, a touching one still merges.
    plan.push_back(plan_row(48'd2500, 48'd2600, 1'b1,
                            hand_result(1'b0, 1'b0, 1'b1, SLOTS, '0, 48'd9)));
    plan.push_back(plan_row(48'd2001, 48'd3005));
    // One wide range that swallows almost the whole table.
    plan.push_back(plan_row(48'd10, 48'd100000000));

    foreach (plan[i]) begin
      send_range(plan[i].lo, plan[i].hi, plan[i].want_known, plan[i].want);
    end

    // Random part. Most ranges land in a narrow window so that the table
    // fills, overflows and merges; some sit exactly against a stored range,
    // some span a lot of the window, and the rest is full-width noise.
    base = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 110 == 0) begin
        case ($urandom_range(0, 3))
          0: base = '0;
          1: base = TOP_OFS - 5000;
          default: begin
            base = rand_ofs();
            if (base > TOP_OFS - 5000) base = TOP_OFS - 5000;
          end
        endcase
      end
      no_idle = (n >= 200) && (n < 320);
      mode = $urandom_range(0, 99);
      if (mode < 6) begin
        b = rand_ofs();
        e = b - ism_pkg::ofs_t'($urandom_range(0, 3));
      end else if (mode < 10) begin
        b = rand_ofs();
        e = rand_ofs();
        if (b > e) {b, e} = {e, b};
      end else if (mode < 14) begin
        b = base + $urandom_range(0, 2000);
        e = b + $urandom_range(1000, 3000);
      end else if (mode < 32 && span_cnt != 0) begin
        k = $urandom_range(0, span_cnt - 1);
        if ($urandom_range(0, 1) && span_hi[k] < TOP_OFS - 100) begin
          b = span_hi[k] + 1'b1;
          e = b + $urandom_range(1, 40);
        end else if (span_lo[k] > 100) begin
          e = span_lo[k] - 1'b1;
          b = e - $urandom_range(1, 40);
        end else begin
          b = span_lo[k];
          e = b + 1'b1;
        end
      end else begin
        b = base + $urandom_range(0, 4000);
        e = b + $urandom_range(1, 60);
      end
      send_range(b, e, 1'b0, '0);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d range transactions, checked %0d results.", sent_cnt, checked_cnt);
    $display("Rejected %0d, merged %0d, dropped on a full table %0d, peak fill %0d.",
             rej_cnt, merge_cnt, ovf_cnt, peak_cnt);
    if (fail_cnt == 0) begin
      $display("interval_set_merge_unit_tb OK");
    end else begin
      $display("interval_set_merge_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/ism_pkg.sv
design/ism_cell.sv
design/interval_set_merge_unit.sv
tb/interval_set_merge_unit_tb.sv
